@@ hw/rtl/mcg_pkg.sv @@
package mcg_pkg;

  localparam int MaxRadiusDef = 64;
  localparam int CoordBitsDef = 12;
  localparam int ResultLimit  = 47;
  localparam int CfgBits      = 13;
  localparam int RadiusBits   = 8;
  localparam int ColorBits    = 32;

  localparam logic [CfgBits-1:0] SurfaceWidthReset  = CfgBits'(640);
  localparam logic [CfgBits-1:0] SurfaceHeightReset = CfgBits'(480);

  typedef enum logic [1:0] {
    CfgSurfaceWidth  = 2'd0,
    CfgSurfaceHeight = 2'd1,
    CfgFillMode      = 2'd2
  } mcg_cfg_index_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StCheck = 2'd1,
    StRun   = 2'd2
  } mcg_state_e;

endpackage

@@ hw/rtl/mcg_step.sv @@
module mcg_step
  import mcg_pkg::*;
#(
  parameter int MAX_RADIUS = MaxRadiusDef
) (
  input  logic signed [$clog2(MAX_RADIUS+2):0]             x_i,
  input  logic signed [$clog2(MAX_RADIUS+2):0]             y_i,
  input  logic signed [$clog2(4*MAX_RADIUS+8):0]           err_i,
  input  logic                                             fill_i,
  output logic signed [$clog2(MAX_RADIUS+2):0]             x_o,
  output logic signed [$clog2(MAX_RADIUS+2):0]             y_o,
  output logic signed [$clog2(4*MAX_RADIUS+8):0]           err_o,
  output logic                                             done_o
);

  localparam int SW = $clog2(MAX_RADIUS+2) + 1;
  localparam int EW = $clog2(4*MAX_RADIUS+8) + 1;

  logic signed [SW-1:0] y1;
  logic signed [SW-1:0] x1;
  logic signed [EW-1:0] diff;
  logic                 take_x;

  // Outline steps x on a strictly positive error, fill also on zero.
  assign take_x = fill_i ? !err_i[EW-1] : (!err_i[EW-1] && (err_i != '0));
  assign y1     = y_i + SW'(1);
  assign x1     = take_x ? (x_i - SW'(1)) : x_i;
  assign diff   = take_x ? (EW'(y1) - EW'(x1)) : EW'(y1);

  // The error grows by twice the difference plus one.
  assign err_o  = err_i + {diff[EW-2:0], 1'b1};
  assign x_o    = x1;
  assign y_o    = y1;
  assign done_o = (x1 < y1);

endmodule

@@ hw/rtl/midpoint_circle_generator.sv @@
// Midpoint circle generator: a request gives center, radius and color, and the
// block walks one octant of the circle, delivering one result per iteration with
// the eight mirrored coordinates, the color and a last flag on the final one.
// fill_mode selects outline pixels or horizontal spans and the stepping rule.
// A request is latched in the idle state and tested in the check state (negative
// radius, or in outline mode a circle wholly off the surface, ends there with no
// result), then one result follows per cycle while the output is not stalled,
// since the single step unit advances x, y and the error once per result: about
// radius/sqrt2 + 1 results, at most 47. The input stays stalled until the last
// result has been loaded into the output register.
module midpoint_circle_generator
  import mcg_pkg::*;
#(
  parameter int MAX_RADIUS = MaxRadiusDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [CfgBits-1:0]           cfg_data_i,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic signed [RadiusBits-1:0] radius_i,
  input  logic [ColorBits-1:0]         pixel_color_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS:0]   left_near_o,
  output logic signed [COORD_BITS:0]   right_near_o,
  output logic signed [COORD_BITS:0]   row_up_near_o,
  output logic signed [COORD_BITS:0]   row_down_near_o,
  output logic signed [COORD_BITS:0]   left_far_o,
  output logic signed [COORD_BITS:0]   right_far_o,
  output logic signed [COORD_BITS:0]   row_up_far_o,
  output logic signed [COORD_BITS:0]   row_down_far_o,
  output logic [ColorBits-1:0]         out_color_o,
  output logic                         last_step_o
);

  localparam int RW   = $clog2(MAX_RADIUS+2);
  localparam int SW   = RW + 1;
  localparam int EW   = $clog2(4*MAX_RADIUS+8) + 1;
  localparam int OW   = COORD_BITS + 1;
  localparam int CntW = $clog2(ResultLimit+1);
  localparam int CmpW = ((COORD_BITS > CfgBits) ? COORD_BITS : CfgBits) + 2;

  // Configuration registers.
  logic [CfgBits-1:0] surf_w_q, surf_h_q;
  logic               fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_w_q <= SurfaceWidthReset;
      surf_h_q <= SurfaceHeightReset;
      fill_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSurfaceWidth:  surf_w_q <= cfg_data_i;
        CfgSurfaceHeight: surf_h_q <= cfg_data_i;
        CfgFillMode:      fill_q   <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  mcg_state_e state_q, state_d;

  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic signed [RadiusBits-1:0] rad_q;
  logic [ColorBits-1:0]         color_q;
  logic signed [SW-1:0]         x_q, y_q, x_nx, y_nx;
  logic signed [EW-1:0]         err_q, err_nx;
  logic [CntW-1:0]              cnt_q;
  logic                         step_done;

  logic                         accept_in;
  logic                         fire;
  logic                         init_en;
  logic                         last;
  logic                         out_valid_q;

  // Saturated radius and the off-surface test.
  logic [RW-1:0]          rsat;
  logic signed [CmpW-1:0] cx_e, cy_e, r_e, w_e, h_e;
  logic signed [CmpW-1:0] x_hi, x_lo, y_hi, y_lo;
  logic                   reject;

  always_comb begin
    if (rad_q > RadiusBits'(MAX_RADIUS)) begin
      rsat = RW'(MAX_RADIUS);
    end else begin
      rsat = rad_q[RW-1:0];
    end
  end

  assign cx_e = CmpW'(cx_q);
  assign cy_e = CmpW'(cy_q);
  assign r_e  = CmpW'(rsat);
  assign w_e  = CmpW'(surf_w_q);
  assign h_e  = CmpW'(surf_h_q);
  assign x_hi = cx_e + r_e;
  assign x_lo = cx_e - r_e;
  assign y_hi = cy_e + r_e;
  assign y_lo = cy_e - r_e;

  assign reject = rad_q[RadiusBits-1] ||
                  (!fill_q && (x_hi[CmpW-1] || (x_lo >= w_e) ||
                               y_hi[CmpW-1] || (y_lo >= h_e)));

  mcg_step #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_step (
    .x_i    (x_q),
    .y_i    (y_q),
    .err_i  (err_q),
    .fill_i (fill_q),
    .x_o    (x_nx),
    .y_o    (y_nx),
    .err_o  (err_nx),
    .done_o (step_done)
  );

  assign last = step_done || (cnt_q == CntW'(ResultLimit - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StCheck;
      StCheck: state_d = reject ? StIdle : StRun;
      StRun:   if (fire && last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    accept_in = 1'b0;
    init_en   = 1'b0;
    fire      = 1'b0;
    case (state_q)
      StIdle:  accept_in = in_valid_i;
      StCheck: init_en = !reject;
      StRun:   fire = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      rad_q       <= '0;
      color_q     <= '0;
      x_q         <= '0;
      y_q         <= '0;
      err_q       <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept_in) begin
        cx_q    <= center_x_i;
        cy_q    <= center_y_i;
        rad_q   <= radius_i;
        color_q <= pixel_color_i;
      end
      if (init_en) begin
        x_q   <= SW'(rsat);
        y_q   <= '0;
        err_q <= EW'(1) - EW'(rsat);
        cnt_q <= '0;
      end else if (fire) begin
        x_q   <= x_nx;
        y_q   <= y_nx;
        err_q <= err_nx;
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // Output register, loaded from the current point before it steps.
  logic signed [OW-1:0] cxo, cyo, xo, yo;

  assign cxo = OW'(cx_q);
  assign cyo = OW'(cy_q);
  assign xo  = OW'(x_q);
  assign yo  = OW'(y_q);

  always_ff @(posedge clk_i) begin
    if (fire) begin
      left_near_o     <= cxo - xo;
      right_near_o    <= cxo + xo;
      row_up_near_o   <= cyo - yo;
      row_down_near_o <= cyo + yo;
      left_far_o      <= cxo - yo;
      right_far_o     <= cxo + yo;
      row_up_far_o    <= cyo - xo;
      row_down_far_o  <= cyo + xo;
      out_color_o     <= color_q;
      last_step_o     <= last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
